/* hdl/hsbp_pkg.sv */
// Shared types and constants for the Huffman symbol bit packer.
package hsbp_pkg;

    localparam int REQ_W        = 2;
    localparam int SYM_W        = 16;
    localparam int CODE_W       = 32;
    localparam int LEN_IN_W     = 6;
    localparam int LEN_MAX_W    = 7;
    localparam int BYTE_W       = 8;

    localparam int DEF_SYMBOL_COUNT  = 65536;
    localparam int DEF_MAX_CODE_BITS = 32;
    localparam int QUEUE_DEPTH       = 4;
    localparam int QCNT_W            = $clog2(QUEUE_DEPTH + 1);

    localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ENCODE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FLUSH  = 2'd2;

    typedef struct packed {
        logic                 is_flush;
        logic [CODE_W-1:0]    word;
        logic [LEN_MAX_W-1:0] len;
    } t_entry;

endpackage

/* hdl/hsbp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module hsbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/hsbp_front.sv */
// Front end: table clearing pass, request accept, table load and code lookup.
module hsbp_front
    import hsbp_pkg::*;
#(
    parameter int SYMBOL_COUNT  = DEF_SYMBOL_COUNT,
    parameter int MAX_CODE_BITS = DEF_MAX_CODE_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [REQ_W-1:0]    i_req_type,
    input  logic [SYM_W-1:0]    i_symbol,
    input  logic [CODE_W-1:0]   i_code_bits,
    input  logic [LEN_IN_W-1:0] i_code_length,
    input  logic [QCNT_W-1:0]   i_q_count,
    output logic                o_push,
    output t_entry              o_entry
);

    localparam int ADDR_W = $clog2(SYMBOL_COUNT);
    localparam int LEN_W  = $clog2(MAX_CODE_BITS + 1);
    localparam int RAM_W  = CODE_W + LEN_W;

    logic              r_clearing;
    logic [ADDR_W-1:0] r_clr_cnt;
    logic              r_s1_valid;
    logic              r_s1_flush;

    logic              accept;
    logic              in_range;
    logic [LEN_W-1:0]  sat_len;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [RAM_W-1:0]  wr_data;
    logic [RAM_W-1:0]  rd_data;
    logic [LEN_W-1:0]  rd_len;

    assign o_in_ready = !r_clearing &&
                        ((32'(i_q_count) + 32'(r_s1_valid)) < QUEUE_DEPTH);
    assign accept     = i_in_valid && o_in_ready;
    assign in_range   = 32'(i_symbol) < 32'(SYMBOL_COUNT);
    assign sat_len    = (32'(i_code_length) > 32'(MAX_CODE_BITS)) ?
                        LEN_W'(MAX_CODE_BITS) : LEN_W'(i_code_length);

    assign wr_en   = r_clearing || (accept && (i_req_type == REQ_LOAD) && in_range);
    assign wr_addr = r_clearing ? r_clr_cnt : i_symbol[ADDR_W-1:0];
    assign wr_data = r_clearing ? '0 : {i_code_bits, sat_len};

    hsbp_ram #(
        .WIDTH (RAM_W),
        .DEPTH (SYMBOL_COUNT)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (i_symbol[ADDR_W-1:0]),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
            r_s1_valid <= 1'b0;
            r_s1_flush <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == ADDR_W'(SYMBOL_COUNT - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            r_s1_valid <= accept && (((i_req_type == REQ_ENCODE) && in_range) ||
                                     (i_req_type == REQ_FLUSH));
            r_s1_flush <= i_req_type == REQ_FLUSH;
        end
    end

    assign rd_len = rd_data[LEN_W-1:0];

    assign o_push           = r_s1_valid && (r_s1_flush || (rd_len != '0));
    assign o_entry.is_flush = r_s1_flush;
    assign o_entry.word     = rd_data[RAM_W-1:LEN_W];
    assign o_entry.len      = LEN_MAX_W'(rd_len);

endmodule

/* hdl/hsbp_queue.sv */
// Short FIFO of looked-up codes and flushes between front and back end.
module hsbp_queue
    import hsbp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_entry            i_entry,
    input  logic              i_pop,
    output logic              o_valid,
    output t_entry            o_head,
    output logic [QCNT_W-1:0] o_count
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_entry            r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_valid = r_count != '0;
    assign o_head  = r_slot[r_rd_ptr];
    assign o_count = r_count;

endmodule

/* hdl/hsbp_back.sv */
// Back end: bit packer, byte emission and output register.
module hsbp_back
    import hsbp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_entry            i_q_head,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_last_byte
);

    logic                 r_busy;
    logic [CODE_W-1:0]    r_word;
    logic [LEN_MAX_W-1:0] r_rem;
    logic [BYTE_W-1:0]    r_pend;
    logic [2:0]           r_pos;
    logic                 r_ovalid;
    logic [BYTE_W-1:0]    r_obyte;
    logic                 r_olast;

    logic                 n_busy;
    logic [CODE_W-1:0]    n_word;
    logic [LEN_MAX_W-1:0] n_rem;
    logic [BYTE_W-1:0]    n_pend;
    logic [2:0]           n_pos;
    logic                 n_ovalid;
    logic [BYTE_W-1:0]    n_obyte;
    logic                 n_olast;

    logic                 out_free;
    logic [3:0]           space;
    logic [3:0]           take;
    logic [BYTE_W-1:0]    mask;
    logic [BYTE_W-1:0]    bits;
    logic [BYTE_W-1:0]    merged;
    logic [3:0]           new_pos;
    logic [LEN_MAX_W-1:0] rem_left;
    logic                 full;

    assign out_free = !r_ovalid || i_out_ready;
    assign space    = 4'd8 - {1'b0, r_pos};
    assign take     = (r_rem < LEN_MAX_W'(space)) ? 4'(r_rem) : space;
    assign mask     = BYTE_W'((9'd1 << take) - 9'd1);
    assign bits     = r_word[BYTE_W-1:0] & mask;
    assign merged   = r_pend | BYTE_W'(bits << r_pos);
    assign new_pos  = {1'b0, r_pos} + take;
    assign full     = new_pos[3];
    assign rem_left = r_rem - LEN_MAX_W'(take);

    assign o_pop = !r_busy && i_q_valid &&
                   (!i_q_head.is_flush || (r_pos == '0) || out_free);

    always_comb begin
        n_busy   = r_busy;
        n_word   = r_word;
        n_rem    = r_rem;
        n_pend   = r_pend;
        n_pos    = r_pos;
        n_ovalid = r_ovalid && !i_out_ready;
        n_obyte  = r_obyte;
        n_olast  = r_olast;
        if (r_busy) begin
            if (!full || out_free) begin
                n_word = r_word >> take;
                n_rem  = rem_left;
                n_busy = rem_left != '0;
                if (full) begin
                    n_ovalid = 1'b1;
                    n_obyte  = merged;
                    n_olast  = rem_left < LEN_MAX_W'(8);
                    n_pend   = '0;
                    n_pos    = '0;
                end else begin
                    n_pend = merged;
                    n_pos  = new_pos[2:0];
                end
            end
        end else if (o_pop) begin
            if (i_q_head.is_flush) begin
                if (r_pos != '0) begin
                    n_ovalid = 1'b1;
                    n_obyte  = r_pend;
                    n_olast  = 1'b1;
                end
                n_pend = '0;
                n_pos  = '0;
            end else begin
                n_busy = 1'b1;
                n_word = i_q_head.word;
                n_rem  = i_q_head.len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word  <= n_word;
        r_rem   <= n_rem;
        r_obyte <= n_obyte;
        r_olast <= n_olast;
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_pend   <= '0;
            r_pos    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_pend   <= n_pend;
            r_pos    <= n_pos;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_byte  = r_obyte;
    assign o_last_byte = r_olast;

endmodule

/* hdl/huffman_symbol_bit_packer.sv */
// Top level of the Huffman symbol bit packer.
//
//  Channel | Handshake                 | Payload
//  --------+---------------------------+------------------------------------------
//  input   | i_in_valid / o_in_ready   | i_req_type i_symbol i_code_bits i_code_length
//  output  | o_out_valid / i_out_ready | o_out_byte o_last_byte
//
// Loads and encodes of unused symbols end in the front end. An encode or flush reaches
// the back end through the table read register and the queue; a flush is then handled on
// its pop, and an encode is loaded into the packer on its pop and then packed byte by byte.
// After reset the code table is cleared one entry per cycle, all SYMBOL_COUNT entries
// (65536 by default), with o_in_ready low. A stalled output holds the packer only while it
// has a byte to emit; up to QUEUE_DEPTH encodes and flushes keep queuing meanwhile.
module huffman_symbol_bit_packer
    import hsbp_pkg::*;
#(
    parameter int SYMBOL_COUNT  = DEF_SYMBOL_COUNT,
    parameter int MAX_CODE_BITS = DEF_MAX_CODE_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [REQ_W-1:0]    i_req_type,
    input  logic [SYM_W-1:0]    i_symbol,
    input  logic [CODE_W-1:0]   i_code_bits,
    input  logic [LEN_IN_W-1:0] i_code_length,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [BYTE_W-1:0]   o_out_byte,
    output logic                o_last_byte
);

    logic              push;
    t_entry            push_entry;
    logic              pop;
    logic              q_valid;
    t_entry            q_head;
    logic [QCNT_W-1:0] q_count;

    hsbp_front #(
        .SYMBOL_COUNT  (SYMBOL_COUNT),
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_symbol      (i_symbol),
        .i_code_bits   (i_code_bits),
        .i_code_length (i_code_length),
        .i_q_count     (q_count),
        .o_push        (push),
        .o_entry       (push_entry)
    );

    hsbp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_head  (q_head),
        .o_count (q_count)
    );

    hsbp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_head    (q_head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte)
    );

endmodule
